// ----- rtl/kvtok_pkg.sv -----
// Package with payload types, character codes and token codes for the key-value tokenizer.
`default_nettype none

package kvtok_pkg;

    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] KIND_WS      = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_BRACE   = 3'd2;
    localparam logic [2:0] KIND_STRING  = 3'd3;
    localparam logic [2:0] KIND_EOF     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_NL_IN_QUOTES  = 2'd1;
    localparam logic [1:0] ERR_END_IN_QUOTES = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG      = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_COMMENT,
        MODE_SLASH,
        MODE_QSTR,
        MODE_USTR,
        MODE_HALT
    } kvtok_mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_final;
    } kvtok_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] begin_offset;
        logic [15:0] end_offset;
        logic [1:0]  error_code;
        logic        run_last;
    } kvtok_out_t;

    typedef struct packed {
        kvtok_out_t [MAX_RESULTS-1:0] res;
        logic [1:0]                   count;
    } kvtok_burst_t;

endpackage

`default_nettype wire

// ----- rtl/keyvalue_text_tokenizer.sv -----
// Top level of the key-value text tokenizer with its result queue.
// Latency: the first result of a byte appears on m_ the cycle after its transfer.
// Throughput: with m_ready high, one byte per cycle while each byte yields
// at most one result; a byte that yields more (up to 3) holds the input until
// one remains, as results leave the three-entry queue one per cycle.
// Reset: aresetn is synchronous and active low; it empties the queue and
// returns the scanner to idle at offset 0.
`default_nettype none

module keyvalue_text_tokenizer
    import kvtok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire kvtok_in_t  s_payload,
    output logic            m_valid,
    input  wire logic       m_ready,
    output kvtok_out_t      m_payload
);

    kvtok_burst_t burst;
    kvtok_out_t   q_reg [MAX_RESULTS];
    kvtok_out_t   q_next [MAX_RESULTS];
    logic [1:0]   cnt_reg, cnt_next;
    logic         s_xfer;
    logic         m_xfer;

    assign m_valid   = (cnt_reg != 2'd0);
    assign m_payload = q_reg[0];
    assign m_xfer    = m_valid && m_ready;
    assign s_ready   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign s_xfer    = s_valid && s_ready;

    kvtok_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_xfer),
        .in_item (s_payload),
        .burst   (burst)
    );

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            q_next[i] = q_reg[i];
        end
        if (s_xfer) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                q_next[i] = burst.res[i];
            end
            cnt_next = burst.count;
        end else if (m_xfer) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg == 2'd1) |-> m_payload.run_last)
        else $error("The last queued result lacks its run_last mark.");

    a_inner_unmarked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg != 2'd1) |-> !m_payload.run_last)
        else $error("A result that is not the last of its byte carries run_last.");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (cnt_reg == $past(burst.count)))
        else $error("The queue did not load the full result set of a transfer.");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.token_kind == KIND_EOF) |->
        (m_payload.begin_offset == m_payload.end_offset
         && m_payload.error_code == ERR_NONE))
        else $error("An end-of-input token has a nonempty span or an error code.");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !s_ready)
        else $error("Input ready while more than one result is pending.");

endmodule

`default_nettype wire

// ----- rtl/kvtok_scan.sv -----
// Scanner state machine that turns one text byte into up to three token results.
`default_nettype none

module kvtok_scan
    import kvtok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  wire kvtok_in_t    in_item,
    output kvtok_burst_t      burst
);

    kvtok_mode_t            mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic [7:0]             c;
    logic                   is_ws;
    logic                   is_nul;
    logic                   at_limit;
    logic [OFFSET_BITS-1:0] pos_inc;

    kvtok_mode_t            feed_mode;
    logic [OFFSET_BITS-1:0] feed_ts;
    logic                   idle_go;
    logic                   advance;
    logic                   close_v;
    logic [2:0]             close_kind;
    logic [1:0]             close_err;
    logic [OFFSET_BITS-1:0] close_begin;
    logic [OFFSET_BITS-1:0] close_end;
    logic                   brace_v;
    logic                   eoi_do;
    kvtok_mode_t            eoi_mode;
    logic [OFFSET_BITS-1:0] eoi_e;

    kvtok_out_t             cand [4];
    logic [3:0]             cand_v;
    logic [1:0]             n;

    function automatic logic [15:0] trim(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    assign c        = in_item.byte_value;
    assign is_ws    = c inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign is_nul   = (c == CH_NUL);
    assign at_limit = &pos_reg;
    assign pos_inc  = pos_reg + OFFSET_BITS'(1);

    always_comb begin
        feed_mode   = mode_reg;
        feed_ts     = ts_reg;
        idle_go     = 1'b0;
        advance     = 1'b0;
        close_v     = 1'b0;
        close_kind  = KIND_WS;
        close_err   = ERR_NONE;
        close_begin = ts_reg;
        close_end   = pos_reg;
        brace_v     = 1'b0;
        eoi_do      = 1'b0;
        eoi_mode    = mode_reg;
        eoi_e       = pos_reg;
        if (mode_reg != MODE_HALT) begin
            if (is_nul) begin
                eoi_do = 1'b1;
            end else if (at_limit) begin
                close_v     = 1'b1;
                close_kind  = KIND_ERROR;
                close_err   = ERR_TOO_LONG;
                close_begin = (mode_reg == MODE_IDLE) ? pos_reg : ts_reg;
                feed_mode   = MODE_HALT;
            end else begin
                advance = 1'b1;
                case (mode_reg)
                    MODE_IDLE: begin
                        idle_go = 1'b1;
                    end
                    MODE_WS: begin
                        if (!is_ws) begin
                            close_v    = 1'b1;
                            close_kind = KIND_WS;
                            idle_go    = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (c == CH_NL) begin
                            close_v    = 1'b1;
                            close_kind = KIND_COMMENT;
                            idle_go    = 1'b1;
                        end
                    end
                    MODE_SLASH: begin
                        if (c == CH_SLASH) begin
                            feed_mode = MODE_COMMENT;
                        end else if (!is_ws) begin
                            feed_mode = MODE_USTR;
                        end else begin
                            close_v    = 1'b1;
                            close_kind = KIND_STRING;
                            idle_go    = 1'b1;
                        end
                    end
                    MODE_QSTR: begin
                        if (c == CH_NL) begin
                            close_v    = 1'b1;
                            close_kind = KIND_ERROR;
                            close_err  = ERR_NL_IN_QUOTES;
                            feed_mode  = MODE_HALT;
                        end else if (c == CH_QUOTE) begin
                            close_v    = 1'b1;
                            close_kind = KIND_STRING;
                            close_end  = pos_inc;
                            feed_mode  = MODE_IDLE;
                        end
                    end
                    MODE_USTR: begin
                        if (is_ws) begin
                            close_v    = 1'b1;
                            close_kind = KIND_STRING;
                            idle_go    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (idle_go) begin
                    feed_ts = pos_reg;
                    if (is_ws) begin
                        feed_mode = MODE_WS;
                    end else if (c == CH_SLASH) begin
                        feed_mode = MODE_SLASH;
                    end else if (c inside {CH_LBRACE, CH_RBRACE}) begin
                        brace_v   = 1'b1;
                        feed_mode = MODE_IDLE;
                    end else if (c == CH_QUOTE) begin
                        feed_mode = MODE_QSTR;
                    end else begin
                        feed_mode = MODE_USTR;
                    end
                end
                if (in_item.is_final && feed_mode != MODE_HALT) begin
                    eoi_do   = 1'b1;
                    eoi_mode = feed_mode;
                    eoi_e    = pos_inc;
                end
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        pos_next  = pos_reg;
        if (step) begin
            if (in_item.is_final) begin
                mode_next = MODE_IDLE;
                ts_next   = '0;
                pos_next  = '0;
            end else begin
                mode_next = eoi_do ? MODE_HALT : feed_mode;
                ts_next   = feed_ts;
                if (advance) begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_comb begin
        cand[0] = '{token_kind: close_kind, begin_offset: trim(close_begin),
                    end_offset: trim(close_end), error_code: close_err, run_last: 1'b0};
        cand[1] = '{token_kind: KIND_BRACE, begin_offset: trim(pos_reg),
                    end_offset: trim(pos_inc), error_code: ERR_NONE, run_last: 1'b0};
        cand[2] = '{token_kind: KIND_WS, begin_offset: trim(feed_ts),
                    end_offset: trim(eoi_e), error_code: ERR_NONE, run_last: 1'b0};
        cand[3] = '{token_kind: KIND_EOF, begin_offset: trim(eoi_e),
                    end_offset: trim(eoi_e), error_code: ERR_NONE, run_last: 1'b0};
        cand_v[0] = close_v;
        cand_v[1] = brace_v;
        cand_v[2] = 1'b0;
        cand_v[3] = eoi_do && (eoi_mode != MODE_QSTR);
        if (eoi_do) begin
            case (eoi_mode)
                MODE_WS: begin
                    cand_v[2] = 1'b1;
                end
                MODE_COMMENT: begin
                    cand_v[2]            = 1'b1;
                    cand[2].token_kind   = KIND_COMMENT;
                end
                MODE_SLASH, MODE_USTR: begin
                    cand_v[2]            = 1'b1;
                    cand[2].token_kind   = KIND_STRING;
                end
                MODE_QSTR: begin
                    cand_v[2]            = 1'b1;
                    cand[2].token_kind   = KIND_ERROR;
                    cand[2].error_code   = ERR_END_IN_QUOTES;
                end
                default: begin
                end
            endcase
        end

        burst.res = '0;
        n         = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && n < 2'(MAX_RESULTS)) begin
                burst.res[n] = cand[i];
                n            = n + 2'd1;
            end
        end
        if (n != 2'd0) begin
            burst.res[n - 2'd1].run_last = 1'b1;
        end
        burst.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            ts_reg   <= '0;
            pos_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire
